### sv/sorted_pair_merge_unit_top_defines.svh
// Assertion macros for the sorted pair merge unit checker
`ifndef SORTED_PAIR_MERGE_UNIT_TOP_DEFINES_SVH
`define SORTED_PAIR_MERGE_UNIT_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define SPMU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define SPMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/spmu_pkg.sv
// Shared types and constants of the sorted pair merge unit
package spmu_pkg;

  localparam int SEQ_DEPTH_DEF = 32;
  localparam int CAT_W         = 8;
  localparam int IMP_W         = 16;
  localparam int OPC_W         = 2;

  localparam logic [OPC_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OPC_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OPC_W-1:0] OP_MERGE    = 2'd2;

  typedef struct packed {
    logic [CAT_W-1:0] category;
    logic [IMP_W-1:0] impact;
  } rec_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

endpackage

### sv/spmu_if.sv
// Valid/ready channel interfaces for the input and result beats
interface spmu_in_if import spmu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [CAT_W-1:0] category;
  logic [IMP_W-1:0] impact;

  modport source (output valid, output opcode, output category, output impact, input ready);
  modport sink   (input valid, input opcode, input category, input impact, output ready);
endinterface

interface spmu_out_if import spmu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAT_W-1:0] out_category;
  logic [IMP_W-1:0] out_impact;
  logic             from_second;
  logic             last_item;

  modport source (output valid, output out_category, output out_impact,
                  output from_second, output last_item, input ready);
  modport sink   (input valid, input out_category, input out_impact,
                  input from_second, input last_item, output ready);
endinterface

### sv/spmu_seq_store.sv
// One record store: single write port, single read port with registered data
module spmu_seq_store import spmu_pkg::*; #(
  parameter int DEPTH = SEQ_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_data
);

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sorted_pair_merge_unit_top.sv
// Top level of the sorted pair merge unit: two record stores and the merge walker
//
//   channel   dir   beat contents                                  handshake
//   in_ch     in    opcode, category, impact                       valid/ready
//   out_ch    out   out_category, out_impact, from_second, last    valid/ready
//
// in_ch.ready is high whenever no merge runs, so appends are taken only then.
// A merge beat emits count_a + count_b records, one a cycle while out_ch
// does not stall; the pace is set by the single read port of each store,
// read one address ahead of the head pointers.
// Reset (rst_n low, synchronous) empties both sequences and the output stage;
// store contents are not cleared and need no clearing pass.
// A stall on out_ch holds the walk: pointers, read addresses and head records
// stay put until the waiting beat is taken.
module sorted_pair_merge_unit_top import spmu_pkg::*; #(
  parameter int SEQ_DEPTH = SEQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spmu_in_if.sink    in_ch,
  spmu_out_if.source out_ch
);

  localparam int AW = $clog2(SEQ_DEPTH);
  localparam int CW = $clog2(SEQ_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SEQ_DEPTH);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic          out_valid_r, out_valid_nxt;
  rec_t          out_rec_r, out_rec_nxt;
  logic          out_src_r, out_src_nxt;
  logic          out_last_r, out_last_nxt;

  logic          acc_in;
  logic          wr_a, wr_b;
  rec_t          in_rec;
  rec_t          head_a, head_b;
  logic          a_done, b_done, a_wins, take_a, emit, last;
  logic [CW-1:0] ia_inc, ib_inc;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign in_rec      = '{category: in_ch.category, impact: in_ch.impact};

  // drop appends to a full sequence
  assign wr_a = acc_in && (in_ch.opcode == OP_APPEND_A) && (cnt_a_r < DEPTH_C);
  assign wr_b = acc_in && (in_ch.opcode == OP_APPEND_B) && (cnt_b_r < DEPTH_C);

  // Stores are read at the next pointer value so the head records are ready
  // in the cycle after each advance.
  spmu_seq_store #(.DEPTH(SEQ_DEPTH), .AW(AW)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (in_rec),
    .rd_addr (ia_nxt[AW-1:0]),
    .rd_data (head_a)
  );

  spmu_seq_store #(.DEPTH(SEQ_DEPTH), .AW(AW)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (in_rec),
    .rd_addr (ib_nxt[AW-1:0]),
    .rd_data (head_b)
  );

  // Head comparison: higher impact first, then lower category, full tie to A.
  assign a_done = (ia_r == cnt_a_r);
  assign b_done = (ib_r == cnt_b_r);
  assign a_wins = (head_a.impact > head_b.impact) ||
                  ((head_a.impact == head_b.impact) && (head_a.category <= head_b.category));
  assign take_a = !a_done && (b_done || a_wins);
  assign ia_inc = ia_r + CW'(1);
  assign ib_inc = ib_r + CW'(1);
  assign last   = take_a ? ((ia_inc == cnt_a_r) && b_done)
                         : ((ib_inc == cnt_b_r) && a_done);

  // the output register is free when empty or being drained this cycle
  assign emit = (state_r == ST_MERGE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rec_nxt   = out_rec_r;
    out_src_nxt   = out_src_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (wr_a) begin
          cnt_a_nxt = cnt_a_r + CW'(1);
        end
        if (wr_b) begin
          cnt_b_nxt = cnt_b_r + CW'(1);
        end
        // an empty merge emits nothing and leaves the counts at zero
        if (acc_in && (in_ch.opcode == OP_MERGE) &&
            ((cnt_a_r != '0) || (cnt_b_r != '0))) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_rec_nxt   = take_a ? head_a : head_b;
          out_src_nxt   = !take_a;
          out_last_nxt  = last;
          if (take_a) begin
            ia_nxt = ia_inc;
          end else begin
            ib_nxt = ib_inc;
          end
          if (last) begin
            // empty both sequences and rewind the walk
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ia_nxt    = '0;
            ib_nxt    = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    out_src_r  <= out_src_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_category = out_rec_r.category;
  assign out_ch.out_impact   = out_rec_r.impact;
  assign out_ch.from_second  = out_src_r;
  assign out_ch.last_item    = out_last_r;

endmodule

### sv/spmu_checker.sv
// Port-level checker for the sorted pair merge unit, bound to the top level
`include "sorted_pair_merge_unit_top_defines.svh"

module spmu_checker import spmu_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [OPC_W-1:0] in_opcode,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CAT_W-1:0] out_category,
  input logic [IMP_W-1:0] out_impact,
  input logic             out_from_second,
  input logic             out_last_item
);

  // a stalled result beat holds
  `SPMU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_category) && $stable(out_impact) && $stable(out_from_second) && $stable(out_last_item), "stalled result beat changed")

  // no input is taken while a merged run is still being emitted
  `SPMU_ASSERT_SAME(a_busy_in_merge, clk, rst_n, out_valid && !out_last_item, !in_ready, "input taken during a merge")

  // an append never produces a result
  `SPMU_ASSERT_NEXT(a_append_silent, clk, rst_n, in_valid && in_ready && !out_valid && (in_opcode == OP_APPEND_A || in_opcode == OP_APPEND_B), !out_valid, "append produced a result")

endmodule

bind sorted_pair_merge_unit_top spmu_checker u_spmu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_opcode       (in_ch.opcode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_category    (out_ch.out_category),
  .out_impact      (out_ch.out_impact),
  .out_from_second (out_ch.from_second),
  .out_last_item   (out_ch.last_item)
);
